### hw/rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared widths, corner sign tables and bundle types for the rotated-box
// hit test pipeline.
// ----------------------------------------------------------------------------
package prt_pkg;

	localparam int COORD_W   = 24;
	localparam int QUAT_W    = 16;
	localparam int TOL_W     = 16;
	localparam int QUAT_FRAC = 14;

	localparam int SQ_W  = 2 * QUAT_W;               // quaternion products
	localparam int N_W   = SQ_W + 1;                 // sum of four squares
	localparam int NUM_W = SQ_W + 2;                 // signed matrix numerators
	localparam int QUO_W = QUAT_FRAC + 1;            // |entry| <= 1.0
	localparam int REM_W = N_W + QUAT_FRAC + 1;      // divider remainder
	localparam int ROT_W = QUAT_W;                   // signed matrix entry

	localparam int POS_W = COORD_W + 2;              // positions, one extra frac bit
	localparam int PR_W  = COORD_W + 1 + ROT_W;      // size * entry
	localparam int V_W   = PR_W + 1;                 // sum of two products
	localparam int K_W   = POS_W + 2;                // corner position
	localparam int E_W   = K_W + 1;                  // edge / relative vectors
	localparam int XP_W  = 2 * E_W;                  // one cross term
	localparam int CR_W  = XP_W + 1;                 // full cross product

	localparam int NCORNER = 4;

	// corner i sits at (+-W, +-H); bit set means the negative side
	localparam logic [NCORNER-1:0] CSX_NEG = 4'b1001;
	localparam logic [NCORNER-1:0] CSY_NEG = 4'b0011;

	localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(1 << QUAT_FRAC);

	typedef struct packed {
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic [COORD_W-1:0]      bw;
		logic [COORD_W-1:0]      bh;
	} geo_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] r00;
		logic signed [ROT_W-1:0] r01;
		logic signed [ROT_W-1:0] r10;
		logic signed [ROT_W-1:0] r11;
	} rot_t;

endpackage

### hw/rtl/prt_quat_norm.sv
// ----------------------------------------------------------------------------
// prt_quat_norm
// Builds the x,y block of the rotation matrix from an unnormalized
// quaternion: squares and products, numerators, then a one-bit-per-stage
// pipelined divider by the squared norm with round-half-away.
// ----------------------------------------------------------------------------
module prt_quat_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [prt_pkg::QUAT_W-1:0]   qx,
	input  logic signed [prt_pkg::QUAT_W-1:0]   qy,
	input  logic signed [prt_pkg::QUAT_W-1:0]   qz,
	input  logic signed [prt_pkg::QUAT_W-1:0]   qw,
	input  prt_pkg::geo_t                       geo_in,
	output logic                                out_valid,
	output prt_pkg::rot_t                       rot_out,
	output prt_pkg::geo_t                       geo_out
);
	import prt_pkg::*;

	localparam int DIV_ST = QUO_W;

	// stage 1: products
	logic                   v_s1;
	logic signed [SQ_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, wz_s1;
	geo_t                   geo_s1;

	// stage 2: norm and numerators (lanes r00, r01, r10, r11)
	logic                    v_s2;
	logic [N_W-1:0]          n_s2;
	logic signed [NUM_W-1:0] m_s2 [NCORNER];
	geo_t                    geo_s2;

	logic [NUM_W-1:0] mag_c [NCORNER];

	// divider chain, index 0 is loaded from stage 2
	logic             dv_s   [DIV_ST+1];
	logic [REM_W-1:0] rem_s  [DIV_ST+1][NCORNER];
	logic [QUO_W-1:0] quo_s  [DIV_ST+1][NCORNER];
	logic [NCORNER-1:0] neg_s [DIV_ST+1];
	logic [N_W-1:0]   dn_s   [DIV_ST+1];
	logic             dnz_s  [DIV_ST+1];
	geo_t             dgeo_s [DIV_ST+1];

	logic signed [ROT_W-1:0] ent_c [NCORNER];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			dv_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			dv_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= qx * qx;
			yy_s1  <= qy * qy;
			zz_s1  <= qz * qz;
			ww_s1  <= qw * qw;
			xy_s1  <= qx * qy;
			wz_s1  <= qw * qz;
			geo_s1 <= geo_in;

			n_s2 <= {1'b0, xx_s1} + {1'b0, yy_s1} + {1'b0, zz_s1} + {1'b0, ww_s1};
			m_s2[0] <= NUM_W'(ww_s1) + NUM_W'(xx_s1) - NUM_W'(yy_s1) - NUM_W'(zz_s1);
			m_s2[1] <= (NUM_W'(xy_s1) - NUM_W'(wz_s1)) <<< 1;
			m_s2[2] <= (NUM_W'(xy_s1) + NUM_W'(wz_s1)) <<< 1;
			m_s2[3] <= NUM_W'(ww_s1) - NUM_W'(xx_s1) + NUM_W'(yy_s1) - NUM_W'(zz_s1);
			geo_s2 <= geo_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < NCORNER; i++) begin
			mag_c[i] = m_s2[i][NUM_W-1] ? NUM_W'(-m_s2[i]) : NUM_W'(m_s2[i]);
		end
	end

	// dividend = |m| * 2^frac + n/2, so the quotient comes out rounded
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCORNER; i++) begin
				rem_s[0][i] <= (REM_W'(mag_c[i]) << QUAT_FRAC) + REM_W'(n_s2 >> 1);
				quo_s[0][i] <= '0;
				neg_s[0][i] <= m_s2[i][NUM_W-1];
			end
			dn_s[0]   <= n_s2;
			dnz_s[0]  <= (n_s2 != '0);
			dgeo_s[0] <= geo_s2;
		end
	end

	for (genvar t = 0; t < DIV_ST; t++) begin : g_div
		localparam int B = QUO_W - 1 - t;

		logic [REM_W-1:0] dsr;
		assign dsr = REM_W'(dn_s[t]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[t+1] <= 1'b0;
			end else if (en) begin
				dv_s[t+1] <= dv_s[t];
			end
		end

		for (genvar i = 0; i < NCORNER; i++) begin : g_lane
			logic ge;
			assign ge = (rem_s[t][i] >= dsr);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[t+1][i] <= ge ? rem_s[t][i] - dsr : rem_s[t][i];
					quo_s[t+1][i] <= quo_s[t][i] | (QUO_W'(ge) << B);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[t+1]  <= neg_s[t];
				dn_s[t+1]   <= dn_s[t];
				dnz_s[t+1]  <= dnz_s[t];
				dgeo_s[t+1] <= dgeo_s[t];
			end
		end
	end

	// zero quaternion falls back to identity
	always_comb begin
		for (int i = 0; i < NCORNER; i++) begin
			if (!dnz_s[DIV_ST]) begin
				ent_c[i] = (i == 0 || i == 3) ? ROT_ONE : '0;
			end else if (neg_s[DIV_ST][i]) begin
				ent_c[i] = -$signed({1'b0, quo_s[DIV_ST][i]});
			end else begin
				ent_c[i] = $signed({1'b0, quo_s[DIV_ST][i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_s[DIV_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_out.r00 <= ent_c[0];
			rot_out.r01 <= ent_c[1];
			rot_out.r10 <= ent_c[2];
			rot_out.r11 <= ent_c[3];
			geo_out     <= dgeo_s[DIV_ST];
		end
	end

endmodule

### hw/rtl/prt_corner.sv
// ----------------------------------------------------------------------------
// prt_corner
// Rotates the four box corners, rounds the offsets half-away and adds the
// box center. Four register stages.
// ----------------------------------------------------------------------------
module prt_corner (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  prt_pkg::rot_t                     rot_in,
	input  prt_pkg::geo_t                     geo_in,
	output logic                              out_valid,
	output logic signed [prt_pkg::K_W-1:0]    kx [prt_pkg::NCORNER],
	output logic signed [prt_pkg::K_W-1:0]    ky [prt_pkg::NCORNER],
	output logic signed [prt_pkg::POS_W-1:0]  px,
	output logic signed [prt_pkg::POS_W-1:0]  py
);
	import prt_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic signed [PR_W-1:0] a_s1, b_s1, c_s1, d_s1;
	geo_t geo_s1, geo_s2, geo_s3;
	logic signed [V_W-1:0] vx_s2 [NCORNER];
	logic signed [V_W-1:0] vy_s2 [NCORNER];
	logic signed [V_W-1:0] rx_c  [NCORNER];
	logic signed [V_W-1:0] ry_c  [NCORNER];
	logic signed [K_W-1:0] ox_s3 [NCORNER];
	logic signed [K_W-1:0] oy_s3 [NCORNER];

	localparam logic signed [V_W-1:0] HALF = V_W'(1) <<< (QUAT_FRAC - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	// round half away: (v + half - sign) >>> frac
	always_comb begin
		for (int i = 0; i < NCORNER; i++) begin
			rx_c[i] = vx_s2[i] + HALF - V_W'(vx_s2[i][V_W-1]);
			ry_c[i] = vy_s2[i] + HALF - V_W'(vy_s2[i][V_W-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= $signed({1'b0, geo_in.bw}) * rot_in.r00;
			b_s1 <= $signed({1'b0, geo_in.bh}) * rot_in.r01;
			c_s1 <= $signed({1'b0, geo_in.bw}) * rot_in.r10;
			d_s1 <= $signed({1'b0, geo_in.bh}) * rot_in.r11;
			geo_s1 <= geo_in;

			for (int i = 0; i < NCORNER; i++) begin
				vx_s2[i] <= (CSX_NEG[i] ? -V_W'(a_s1) : V_W'(a_s1))
					+ (CSY_NEG[i] ? -V_W'(b_s1) : V_W'(b_s1));
				vy_s2[i] <= (CSX_NEG[i] ? -V_W'(c_s1) : V_W'(c_s1))
					+ (CSY_NEG[i] ? -V_W'(d_s1) : V_W'(d_s1));
			end
			geo_s2 <= geo_s1;

			for (int i = 0; i < NCORNER; i++) begin
				ox_s3[i] <= rx_c[i][QUAT_FRAC +: K_W];
				oy_s3[i] <= ry_c[i][QUAT_FRAC +: K_W];
			end
			geo_s3 <= geo_s2;

			for (int i = 0; i < NCORNER; i++) begin
				kx[i] <= K_W'(geo_s3.cx) + ox_s3[i];
				ky[i] <= K_W'(geo_s3.cy) + oy_s3[i];
			end
			px <= geo_s3.px;
			py <= geo_s3.py;
		end
	end

endmodule

### hw/rtl/prt_edge.sv
// ----------------------------------------------------------------------------
// prt_edge
// Per-edge cross products against the query point, tolerance skip and the
// final sign vote. The last stage is the block's output register.
// ----------------------------------------------------------------------------
module prt_edge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [prt_pkg::K_W-1:0]    kx [prt_pkg::NCORNER],
	input  logic signed [prt_pkg::K_W-1:0]    ky [prt_pkg::NCORNER],
	input  logic signed [prt_pkg::POS_W-1:0]  px,
	input  logic signed [prt_pkg::POS_W-1:0]  py,
	input  logic [prt_pkg::TOL_W-1:0]         tol,
	output logic                              out_valid,
	output logic                              in_box
);
	import prt_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [E_W-1:0]  ex_s1 [NCORNER];
	logic signed [E_W-1:0]  ey_s1 [NCORNER];
	logic signed [E_W-1:0]  rx_s1 [NCORNER];
	logic signed [E_W-1:0]  ry_s1 [NCORNER];
	logic signed [XP_W-1:0] pa_s2 [NCORNER];
	logic signed [XP_W-1:0] pb_s2 [NCORNER];
	logic signed [CR_W-1:0] cr_s3 [NCORNER];
	logic [NCORNER-1:0]     act_s4, pos_s4;
	logic signed [CR_W-1:0] tol4;

	// skip threshold is four times the register (two extra fraction bits)
	assign tol4 = CR_W'($signed({1'b0, tol, 2'b00}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCORNER; i++) begin
				ex_s1[i] <= E_W'(kx[(i + 1) % NCORNER]) - E_W'(kx[i]);
				ey_s1[i] <= E_W'(ky[(i + 1) % NCORNER]) - E_W'(ky[i]);
				rx_s1[i] <= E_W'(px) - E_W'(kx[i]);
				ry_s1[i] <= E_W'(py) - E_W'(ky[i]);
			end
			for (int i = 0; i < NCORNER; i++) begin
				pa_s2[i] <= ex_s1[i] * ry_s1[i];
				pb_s2[i] <= ey_s1[i] * rx_s1[i];
			end
			for (int i = 0; i < NCORNER; i++) begin
				cr_s3[i] <= CR_W'(pa_s2[i]) - CR_W'(pb_s2[i]);
			end
			for (int i = 0; i < NCORNER; i++) begin
				act_s4[i] <= (cr_s3[i] > tol4) || (cr_s3[i] < -tol4);
				pos_s4[i] <= ~cr_s3[i][CR_W-1];
			end
			// outside only when kept edges disagree in sign
			in_box <= !((|(act_s4 & pos_s4)) && (|(act_s4 & ~pos_s4)));
		end
	end

endmodule

### hw/rtl/point_in_rotated_rect_test_core.sv
// ----------------------------------------------------------------------------
// point_in_rotated_rect_test_core
// Hit test of a point against a quaternion-oriented box.
//
// Input channel (in_valid/in_ready) carries one query per transfer: point,
// anchor, box size and an unnormalized quaternion. Output channel
// (out_valid/out_ready) returns inside_res, one result per query, in order.
// cfg_we/cfg_wdata write the collinear tolerance; write only while idle.
//
// Throughput: one query per cycle unless the output stalls. The latency from
// input transfer to out_valid is set mostly by the 15-stage norm divider
// (one quotient bit per stage) plus product, corner and cross-product stages.
//
// All stages advance together; when out_valid is high and out_ready low the
// whole pipe holds and in_ready drops, nothing is lost or repeated.
// Reset clears all stage valid bits and sets the tolerance to zero.
// ----------------------------------------------------------------------------
module point_in_rotated_rect_test_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [prt_pkg::TOL_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [prt_pkg::COORD_W-1:0] point_x,
	input  logic signed [prt_pkg::COORD_W-1:0] point_y,
	input  logic signed [prt_pkg::COORD_W-1:0] anchor_x,
	input  logic signed [prt_pkg::COORD_W-1:0] anchor_y,
	input  logic [prt_pkg::COORD_W-1:0]       box_width,
	input  logic [prt_pkg::COORD_W-1:0]       box_height,
	input  logic signed [prt_pkg::QUAT_W-1:0] quat_x,
	input  logic signed [prt_pkg::QUAT_W-1:0] quat_y,
	input  logic signed [prt_pkg::QUAT_W-1:0] quat_z,
	input  logic signed [prt_pkg::QUAT_W-1:0] quat_w,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              inside_res
);
	import prt_pkg::*;

	logic              en;
	logic [TOL_W-1:0]  tol_q;
	geo_t              geo_c, geo_n;
	rot_t              rot_n;
	logic              qv, cv;
	logic signed [K_W-1:0]   kx [NCORNER];
	logic signed [K_W-1:0]   ky [NCORNER];
	logic signed [POS_W-1:0] px, py;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// positions carry one extra fraction bit; center y is the anchor minus H/2
	always_comb begin
		geo_c.px = $signed({point_x[COORD_W-1], point_x, 1'b0});
		geo_c.py = $signed({point_y[COORD_W-1], point_y, 1'b0});
		geo_c.cx = $signed({anchor_x[COORD_W-1], anchor_x, 1'b0});
		geo_c.cy = $signed({anchor_y[COORD_W-1], anchor_y, 1'b0})
			- $signed({2'b00, box_height});
		geo_c.bw = box_width;
		geo_c.bh = box_height;
	end

	prt_quat_norm u_quat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.qx        (quat_x),
		.qy        (quat_y),
		.qz        (quat_z),
		.qw        (quat_w),
		.geo_in    (geo_c),
		.out_valid (qv),
		.rot_out   (rot_n),
		.geo_out   (geo_n)
	);

	prt_corner u_corner (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (qv),
		.rot_in    (rot_n),
		.geo_in    (geo_n),
		.out_valid (cv),
		.kx        (kx),
		.ky        (ky),
		.px        (px),
		.py        (py)
	);

	prt_edge u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cv),
		.kx        (kx),
		.ky        (ky),
		.px        (px),
		.py        (py),
		.tol       (tol_q),
		.out_valid (out_valid),
		.in_box    (inside_res)
	);

endmodule
